### design/sdn_pkg.sv
package sdn_pkg;

  localparam int ROW_W          = 8;
  localparam int VAL_W          = 32;
  localparam int PC_W           = 9;
  localparam int MAX_POINTS_DEF = 256;
  localparam int QUEUE_DEPTH    = 4;

  localparam logic [PC_W-1:0]  PC_RESET  = PC_W'(256);
  localparam logic [VAL_W-1:0] ROOT_ZERO = '1;   // root taken for a zero degree

  localparam logic REQ_DEGREE = 1'b0;
  localparam logic REQ_NORM   = 1'b1;

  typedef struct packed {
    logic             req_type;
    logic [ROW_W-1:0] row_index;
    logic [ROW_W-1:0] col_index;
    logic [VAL_W-1:0] value;
  } sdn_item_t;

endpackage

### design/sdn_front.sv
module sdn_front import sdn_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic             in_req_type,
  input  logic [ROW_W-1:0] in_row_index,
  input  logic [ROW_W-1:0] in_col_index,
  input  logic [VAL_W-1:0] in_value,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [PC_W-1:0]  cfg_point_count,
  input  logic             q_full,
  output logic             push,
  output sdn_item_t        push_item
);

  // wide enough for point_count, MAX_POINTS and an index
  localparam int MW = $clog2(MAX_POINTS + 1);
  localparam int NW = (MW > PC_W) ? MW : PC_W;

  logic [PC_W-1:0] pc_r;
  logic [NW-1:0]   pc_x, max_x, n_eff, row_x, col_x;
  logic            accept, row_ok, col_ok, keep;

  assign cfg_ready = 1'b1;
  assign busy      = q_full;
  assign accept    = start && !busy;

  assign pc_x  = NW'(pc_r);
  assign max_x = NW'(MAX_POINTS);
  assign n_eff = (pc_x > max_x) ? max_x : pc_x;
  assign row_x = NW'(in_row_index);
  assign col_x = NW'(in_col_index);

  assign row_ok = row_x < n_eff;
  assign col_ok = col_x < n_eff;
  // degree loads ignore the column
  assign keep   = row_ok && (col_ok || (in_req_type == REQ_DEGREE));
  assign push   = accept && keep;

  assign push_item.req_type  = in_req_type;
  assign push_item.row_index = in_row_index;
  assign push_item.col_index = in_col_index;
  assign push_item.value     = in_value;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= PC_RESET;
    end else if (cfg_valid && cfg_ready) begin
      pc_r <= cfg_point_count;
    end
  end

endmodule

### design/sdn_queue.sv
module sdn_queue import sdn_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  sdn_item_t push_item,
  input  logic      pop,
  output sdn_item_t head,
  output logic      head_vld,
  output logic      full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  sdn_item_t         slot_r [DEPTH];
  logic [PW-1:0]     wp_r, rp_r;
  logic [CW-1:0]     cnt_r, cnt_nxt;

  assign head     = slot_r[rp_r];
  assign head_vld = cnt_r != '0;
  assign full     = cnt_r == CW'(DEPTH);

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wp_r <= (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + PW'(1);
      end
      if (pop) begin
        rp_r <= (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= push_item;
    end
  end

endmodule

### design/sdn_isqrt.sv
module sdn_isqrt import sdn_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [VAL_W-1:0] degree,
  output logic             done,
  output logic [VAL_W-1:0] root
);

  // root = floor(sqrt(floor(2^56 / degree))): restoring divide, then
  // digit-by-digit square root, one bit per cycle each
  localparam int DIV_STEPS  = 57;
  localparam int SQRT_STEPS = 29;
  localparam int QW         = 2 * SQRT_STEPS;   // quotient padded to even width
  localparam int RW         = VAL_W + 1;
  localparam int SW         = 6;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_DIV  = 2'd1;
  localparam logic [1:0] PH_SQRT = 2'd2;

  logic [1:0]            phase_r;
  logic [SW-1:0]         step_r;
  logic                  done_r;
  logic [VAL_W-1:0]      den_r;
  logic [RW-1:0]         rem_r;
  logic [QW-1:0]         quo_r;
  logic [SQRT_STEPS-1:0] root_r;

  logic [RW-1:0] div_sh, div_rem, den_x, sq_sh, sq_trial, sq_rem;
  logic          div_ge, sq_ge;

  // dividend is a single one at the top, so only the first step brings in a 1
  assign div_sh  = {rem_r[RW-2:0], (step_r == '0)};
  assign den_x   = {1'b0, den_r};
  assign div_ge  = div_sh >= den_x;
  assign div_rem = div_ge ? div_sh - den_x : div_sh;

  assign sq_sh    = {rem_r[RW-3:0], quo_r[QW-1 -: 2]};
  assign sq_trial = RW'({root_r, 2'b01});
  assign sq_ge    = sq_sh >= sq_trial;
  assign sq_rem   = sq_ge ? sq_sh - sq_trial : sq_sh;

  assign done = done_r;
  assign root = VAL_W'(root_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      step_r  <= '0;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (phase_r)
        PH_IDLE: begin
          if (start) begin
            phase_r <= PH_DIV;
            step_r  <= '0;
          end
        end
        PH_DIV: begin
          if (step_r == SW'(DIV_STEPS - 1)) begin
            phase_r <= PH_SQRT;
            step_r  <= '0;
          end else begin
            step_r <= step_r + SW'(1);
          end
        end
        PH_SQRT: begin
          if (step_r == SW'(SQRT_STEPS - 1)) begin
            phase_r <= PH_IDLE;
            done_r  <= 1'b1;
          end else begin
            step_r <= step_r + SW'(1);
          end
        end
        default: begin
          phase_r <= PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (phase_r)
      PH_IDLE: begin
        if (start) begin
          den_r <= degree;
          rem_r <= '0;
          quo_r <= '0;
        end
      end
      PH_DIV: begin
        quo_r <= {quo_r[QW-2:0], div_ge};
        if (step_r == SW'(DIV_STEPS - 1)) begin
          rem_r  <= '0;
          root_r <= '0;
        end else begin
          rem_r <= div_rem;
        end
      end
      PH_SQRT: begin
        rem_r  <= sq_rem;
        quo_r  <= {quo_r[QW-3:0], 2'b00};
        root_r <= {root_r[SQRT_STEPS-2:0], sq_ge};
      end
      default: begin
        rem_r <= rem_r;
      end
    endcase
  end

endmodule

### design/sdn_back.sv
module sdn_back import sdn_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  sdn_item_t        head,
  input  logic             head_vld,
  output logic             pop,
  output logic             out_valid,
  output logic [VAL_W-1:0] out_value,
  output logic             out_sat
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int XW = (AW > ROW_W) ? AW : ROW_W;
  localparam int PW = 2 * VAL_W;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_ROOT = 1'b1;

  logic             state_r, state_nxt;
  logic [VAL_W-1:0] root_mem [MAX_POINTS];

  logic [XW-1:0]    row_x, col_x;
  logic [AW-1:0]    row_a, col_a, wr_addr, wa_r;
  logic             is_deg, iq_start, iq_done, wr_en, rd_en;
  logic [VAL_W-1:0] iq_root, wr_data;

  // pipeline
  logic             s1_vld_r, s2_vld_r, s3_vld_r, out_vld_r;
  logic [VAL_W-1:0] v1_r, rr_r, rc_r, rc2_r;
  logic [PW-1:0]    p1_r, x_r, y_r, mid;
  logic [VAL_W-1:0] out_value_r;
  logic             out_sat_r, sat;

  assign row_x = XW'(head.row_index);
  assign col_x = XW'(head.col_index);
  assign row_a = row_x[AW-1:0];
  assign col_a = col_x[AW-1:0];

  assign is_deg   = head.req_type == REQ_DEGREE;
  assign pop      = (state_r == ST_IDLE) && head_vld;
  assign iq_start = pop && is_deg && (head.value != '0);
  assign rd_en    = pop && !is_deg;
  assign wr_en    = (pop && is_deg && (head.value == '0)) || ((state_r == ST_ROOT) && iq_done);
  assign wr_data  = (state_r == ST_ROOT) ? iq_root : ROOT_ZERO;
  assign wr_addr  = (state_r == ST_ROOT) ? wa_r : row_a;

  sdn_isqrt u_isqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (iq_start),
    .degree (head.value),
    .done   (iq_done),
    .root   (iq_root)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (iq_start) state_nxt = ST_ROOT;
      ST_ROOT: if (iq_done)  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      s1_vld_r  <= rd_en;
      s2_vld_r  <= s1_vld_r;
      s3_vld_r  <= s2_vld_r;
      out_vld_r <= s3_vld_r;
    end
  end

  // root table: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (wr_en) begin
      root_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rr_r <= root_mem[row_a];
      rc_r <= root_mem[col_a];
    end
  end

  assign mid = y_r + PW'(x_r[PW-1:VAL_W]);
  assign sat = mid[PW-1:40] != '0;

  always_ff @(posedge clk) begin
    if (iq_start) begin
      wa_r <= row_a;
    end
    if (rd_en) begin
      v1_r <= head.value;
    end
    p1_r        <= PW'(v1_r) * PW'(rr_r);
    rc2_r       <= rc_r;
    x_r         <= PW'(p1_r[VAL_W-1:0]) * PW'(rc2_r);
    y_r         <= PW'(p1_r[PW-1:VAL_W]) * PW'(rc2_r);
    out_value_r <= sat ? '1 : mid[39:8];
    out_sat_r   <= s3_vld_r && sat;
  end

  assign out_valid = out_vld_r;
  assign out_value = out_value_r;
  assign out_sat   = out_sat_r;

endmodule

### design/symmetric_degree_normalizer.sv
// Normalize word: it passes the queue, the root table read, the product and output registers.
// Normalize words sustain one per cycle while no root is computed; the four-stage multiply
// pipeline sets this. Degree word: a nonzero degree holds the queue for a 57-step divide
// plus a 29-step root in the shared root unit; a zero degree is written as it is popped.
// Results cannot be stalled. rst_n is synchronous, active low: control and queue
// clear, point_count returns to 256, the root table is left as it was.
module symmetric_degree_normalizer import sdn_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  // input words
  input  logic             start,
  output logic             busy,
  input  logic             in_req_type,
  input  logic [ROW_W-1:0] in_row_index,
  input  logic [ROW_W-1:0] in_col_index,
  input  logic [VAL_W-1:0] in_value,
  // result words
  output logic             out_valid,
  output logic [VAL_W-1:0] out_normalized_value,
  output logic             out_saturated,
  // point_count register
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [PC_W-1:0]  cfg_point_count
);

  sdn_item_t push_item, head;
  logic      push, pop, head_vld, q_full;

  // front: point_count register, range check, drops out-of-range words
  sdn_front #(.MAX_POINTS(MAX_POINTS)) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_req_type     (in_req_type),
    .in_row_index    (in_row_index),
    .in_col_index    (in_col_index),
    .in_value        (in_value),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_point_count (cfg_point_count),
    .q_full          (q_full),
    .push            (push),
    .push_item       (push_item)
  );

  // short queue so the front keeps taking words while a root is computed
  sdn_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .head_vld  (head_vld),
    .full      (q_full)
  );

  // back: root table, root unit, multiply pipeline
  sdn_back #(.MAX_POINTS(MAX_POINTS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .head_vld  (head_vld),
    .pop       (pop),
    .out_valid (out_valid),
    .out_value (out_normalized_value),
    .out_sat   (out_saturated)
  );

endmodule

### design/sdn_checker.sv
module sdn_checker import sdn_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             start,
  input logic             busy,
  input logic             out_valid,
  input logic [VAL_W-1:0] out_normalized_value,
  input logic             out_saturated
);

  // a saturated word always carries the ceiling value
  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_saturated |-> (out_normalized_value == '1))
    else $error("saturated word without full-scale value");

  a_sat_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !out_saturated)
    else $error("saturated flag outside a result word");

  // reset empties the queue and the pipeline
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && !busy))
    else $error("state left over after reset");

  // the queue only fills on an accepted word
  a_busy_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start && !busy))
    else $error("busy raised without an accepted word");

endmodule

bind symmetric_degree_normalizer sdn_checker u_sdn_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .start                (start),
  .busy                 (busy),
  .out_valid            (out_valid),
  .out_normalized_value (out_normalized_value),
  .out_saturated        (out_saturated)
);
